@@ sv/pmdio_pkg.sv @@
// ----------------------------------------------------------------------------
// Paged MDIO master package
// Widths, frame constants, register map and the frame phase type shared by
// the paged MDIO master and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package pmdio_pkg;

   // Default length of the preamble of ones in front of every frame.
   localparam int PREAMBLE_BITS_DEFAULT = 32;

   // Item field widths.
   localparam int ADDR_WIDTH  = 7;
   localparam int DATA_WIDTH  = 16;
   localparam int REG_WIDTH   = 5;
   localparam int PAGE_WIDTH  = 2;
   localparam int PHY_WIDTH   = 5;

   // Frame body widths (without preamble) and storage widths.
   localparam int FRAME_WIDTH      = 33;
   localparam int WRITE_FRAME_BITS = 33;
   localparam int READ_FRAME_BITS  = 32;
   localparam int COUNT_WIDTH      = 7;
   localparam int INDEX_WIDTH      = 6;

   // Start and opcode bits for Clause 22 frames.
   localparam logic [3:0] WRITE_START_OP = 4'b0101;
   localparam logic [3:0] READ_START_OP  = 4'b0110;
   localparam logic [1:0] WRITE_TURNAROUND = 2'b10;

   // Page select register and the flag bit that goes with the page number.
   localparam logic [REG_WIDTH-1:0]  PAGE_SEL_REG  = 5'h1F;
   localparam logic [DATA_WIDTH-1:0] PAGE_SEL_FLAG = 16'h0010;

   // Configuration register file.
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic CSR_IDX_PHY_ADDRESS = 1'b0;
   localparam logic [PHY_WIDTH-1:0] PHY_ADDRESS_RESET = 5'd4;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_PAGE,
      PHASE_ACCESS
   } phase_type;

endpackage

`default_nettype wire

@@ sv/pmdio_req_if.sv @@
// ----------------------------------------------------------------------------
// Paged MDIO request channel
// Valid/ready channel carrying one request or tick item to the MDIO master.
// ----------------------------------------------------------------------------
`default_nettype none

interface pmdio_req_if;
   import pmdio_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  func;
   logic                  is_write;
   logic [ADDR_WIDTH-1:0] reg_addr;
   logic [DATA_WIDTH-1:0] write_data;
   logic                  mdio_in;

   modport source (
      output valid, func, is_write, reg_addr, write_data, mdio_in,
      input  ready
   );

   modport sink (
      input  valid, func, is_write, reg_addr, write_data, mdio_in,
      output ready
   );
endinterface

`default_nettype wire

@@ sv/pmdio_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Paged MDIO result channel
// Valid/ready channel carrying one result item from the MDIO master.
// ----------------------------------------------------------------------------
`default_nettype none

interface pmdio_rsp_if;
   import pmdio_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  mdio_out;
   logic                  mdio_drive;
   logic                  clock_pulse;
   logic                  read_valid;
   logic [DATA_WIDTH-1:0] read_data;
   logic                  access_done;
   logic                  rejected;
   logic                  busy_res;

   modport source (
      output valid, mdio_out, mdio_drive, clock_pulse, read_valid, read_data,
             access_done, rejected, busy_res,
      input  ready
   );

   modport sink (
      input  valid, mdio_out, mdio_drive, clock_pulse, read_valid, read_data,
             access_done, rejected, busy_res,
      output ready
   );
endinterface

`default_nettype wire

@@ sv/paged_mdio_master_top.sv @@
// ----------------------------------------------------------------------------
// Paged MDIO master
// Clause 22 MDIO master that inserts a page-select write in front of an
// access whenever the requested page differs from the cached one.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle. A request item (func = 1) that
// arrives while idle is latched and produces no result; the frame goes out one
// bit per following tick item (func = 0), and each tick returns one result
// carrying the MDIO level, the drive enable and the MDC pulse flag. A request
// while a frame is running is dropped and answered with a result that has
// rejected set. A page change costs one extra write frame of PREAMBLE_BITS+33
// ticks; a write access takes PREAMBLE_BITS+33 ticks and a read access
// PREAMBLE_BITS+32 ticks, the last tick of an access flagging access_done (and
// read_valid with the collected data for a read). All per-item work is a
// single pass of logic between the frame state registers and the result
// register, so an item is accepted every cycle while the result register is
// empty or being emptied in the same cycle. The PHY address is written
// through the APB port at byte address 0 and is captured into each frame
// when the frame is built.
`default_nettype none

module paged_mdio_master_top #(
   parameter int PREAMBLE_BITS = pmdio_pkg::PREAMBLE_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   pmdio_req_if.sink                                req_chan,
   pmdio_rsp_if.source                              rsp_chan,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [pmdio_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [pmdio_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [pmdio_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                     csr_pready
);
   import pmdio_pkg::*;

   // Tick counts loaded when a frame is built: preamble plus frame body.
   localparam logic [COUNT_WIDTH-1:0] WRITE_COUNT =
      COUNT_WIDTH'(PREAMBLE_BITS + WRITE_FRAME_BITS);
   localparam logic [COUNT_WIDTH-1:0] READ_COUNT =
      COUNT_WIDTH'(PREAMBLE_BITS + READ_FRAME_BITS);
   localparam logic [COUNT_WIDTH-1:0] WRITE_LEN = COUNT_WIDTH'(WRITE_FRAME_BITS);
   localparam logic [COUNT_WIDTH-1:0] READ_LEN  = COUNT_WIDTH'(READ_FRAME_BITS);
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
   // Released sample window of a read frame: tick positions 17 down to 2.
   localparam logic [COUNT_WIDTH-1:0] SAMPLE_HI = COUNT_WIDTH'(DATA_WIDTH + 1);
   localparam logic [COUNT_WIDTH-1:0] SAMPLE_LO = COUNT_WIDTH'(2);

   // Write frame body, most significant bit first on the wire.
   function automatic logic [FRAME_WIDTH-1:0] write_frame(
      input logic [PHY_WIDTH-1:0]  phy,
      input logic [REG_WIDTH-1:0]  rg,
      input logic [DATA_WIDTH-1:0] data
   );
      return {WRITE_START_OP, phy, rg, WRITE_TURNAROUND, data, 1'b1};
   endfunction

   // Read frame body: the data bits are placeholders, the line is released
   // while they would be sent.
   function automatic logic [FRAME_WIDTH-1:0] read_frame(
      input logic [PHY_WIDTH-1:0] phy,
      input logic [REG_WIDTH-1:0] rg
   );
      return {1'b0, READ_START_OP, phy, rg, 1'b1, {DATA_WIDTH{1'b0}}, 1'b1};
   endfunction

   // Frame state.
   phase_type                phase_ff, phase_in;
   logic [PAGE_WIDTH-1:0]    cached_page_ff, cached_page_in;
   logic [FRAME_WIDTH-1:0]   frame_shift_ff, frame_shift_in;
   logic [COUNT_WIDTH-1:0]   bit_count_ff, bit_count_in;
   logic                     pend_write_ff, pend_write_in;
   logic [REG_WIDTH-1:0]     pend_reg_ff, pend_reg_in;
   logic [DATA_WIDTH-1:0]    pend_data_ff, pend_data_in;
   logic [DATA_WIDTH-1:0]    read_shift_ff, read_shift_in;
   logic [PHY_WIDTH-1:0]     phy_address_ff, phy_address_in;

   // Result register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_mdio_out_ff, rsp_mdio_out_in;
   logic                     rsp_mdio_drive_ff, rsp_mdio_drive_in;
   logic                     rsp_clock_pulse_ff, rsp_clock_pulse_in;
   logic                     rsp_read_valid_ff, rsp_read_valid_in;
   logic [DATA_WIDTH-1:0]    rsp_read_data_ff, rsp_read_data_in;
   logic                     rsp_access_done_ff, rsp_access_done_in;
   logic                     rsp_rejected_ff, rsp_rejected_in;
   logic                     rsp_busy_res_ff, rsp_busy_res_in;

   // Per-item working signals.
   logic                     req_fire;
   logic                     rsp_fire;
   logic                     busy;
   logic                     is_read;
   logic [COUNT_WIDTH-1:0]   pos;
   logic [COUNT_WIDTH-1:0]   pos_minus1;
   logic [COUNT_WIDTH-1:0]   frame_len;
   logic [FRAME_WIDTH-1:0]   frame_shifted;
   logic [PAGE_WIDTH-1:0]    req_page;
   logic                     out_load;
   logic                     start_acc;
   logic                     st_write;
   logic [REG_WIDTH-1:0]     st_reg;
   logic [DATA_WIDTH-1:0]    st_data;
   logic                     csr_write;

   // A new item is taken whenever the result register is free, or frees up in
   // this same cycle, so ticks flow at one per clock.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_valid_ff && rsp_chan.ready;

   assign busy     = (phase_ff != PHASE_IDLE);
   assign is_read  = (phase_ff == PHASE_ACCESS) && !pend_write_ff;
   // Position in the frame counted down; a zero count behaves as the last bit.
   assign pos        = (bit_count_ff == '0) ? COUNT_ONE : bit_count_ff;
   assign pos_minus1 = pos - COUNT_ONE;
   assign frame_len  = is_read ? READ_LEN : WRITE_LEN;
   assign frame_shifted = frame_shift_ff >> pos_minus1[INDEX_WIDTH-1:0];
   assign req_page   = req_chan.reg_addr[ADDR_WIDTH-1 -: PAGE_WIDTH];

   always_comb begin
      phase_in       = phase_ff;
      cached_page_in = cached_page_ff;
      frame_shift_in = frame_shift_ff;
      bit_count_in   = bit_count_ff;
      pend_write_in  = pend_write_ff;
      pend_reg_in    = pend_reg_ff;
      pend_data_in   = pend_data_ff;
      read_shift_in  = read_shift_ff;

      out_load           = 1'b0;
      rsp_mdio_out_in    = 1'b0;
      rsp_mdio_drive_in  = 1'b0;
      rsp_clock_pulse_in = 1'b0;
      rsp_read_valid_in  = 1'b0;
      rsp_read_data_in   = '0;
      rsp_access_done_in = 1'b0;
      rsp_rejected_in    = 1'b0;
      rsp_busy_res_in    = 1'b0;

      start_acc = 1'b0;
      st_write  = pend_write_ff;
      st_reg    = pend_reg_ff;
      st_data   = pend_data_ff;

      if (req_fire) begin
         if (req_chan.func) begin
            if (busy) begin
               // Request during a frame: dropped and reported.
               out_load        = 1'b1;
               rsp_rejected_in = 1'b1;
               rsp_busy_res_in = 1'b1;
            end else begin
               pend_write_in = req_chan.is_write;
               pend_reg_in   = req_chan.reg_addr[REG_WIDTH-1:0];
               pend_data_in  = req_chan.write_data;
               if (req_page != cached_page_ff) begin
                  frame_shift_in = write_frame(phy_address_ff, PAGE_SEL_REG,
                     {{(DATA_WIDTH-PAGE_WIDTH){1'b0}}, req_page} | PAGE_SEL_FLAG);
                  bit_count_in   = WRITE_COUNT;
                  cached_page_in = req_page;
                  read_shift_in  = '0;
                  phase_in       = PHASE_PAGE;
               end else begin
                  start_acc = 1'b1;
                  st_write  = req_chan.is_write;
                  st_reg    = req_chan.reg_addr[REG_WIDTH-1:0];
                  st_data   = req_chan.write_data;
               end
            end
         end else begin
            out_load = 1'b1;
            if (busy) begin
               if (pos > frame_len) begin
                  // Preamble.
                  rsp_mdio_out_in   = 1'b1;
                  rsp_mdio_drive_in = 1'b1;
               end else if (is_read && (pos >= SAMPLE_LO) && (pos <= SAMPLE_HI)) begin
                  // Line released, the device drives the read data.
                  read_shift_in = {read_shift_ff[DATA_WIDTH-2:0], req_chan.mdio_in};
               end else begin
                  rsp_mdio_out_in   = frame_shifted[0];
                  rsp_mdio_drive_in = 1'b1;
               end
               rsp_clock_pulse_in = 1'b1;
               rsp_busy_res_in    = 1'b1;
               bit_count_in       = pos_minus1;
               if (pos == COUNT_ONE) begin
                  if (phase_ff == PHASE_PAGE) begin
                     // Page select finished: the access frame follows at once.
                     start_acc = 1'b1;
                  end else begin
                     phase_in           = PHASE_IDLE;
                     rsp_access_done_in = 1'b1;
                     if (is_read) begin
                        rsp_read_valid_in = 1'b1;
                        rsp_read_data_in  = read_shift_ff;
                     end
                  end
               end
            end
         end
      end

      if (start_acc) begin
         read_shift_in = '0;
         phase_in      = PHASE_ACCESS;
         if (st_write) begin
            frame_shift_in = write_frame(phy_address_ff, st_reg, st_data);
            bit_count_in   = WRITE_COUNT;
         end else begin
            frame_shift_in = read_frame(phy_address_ff, st_reg);
            bit_count_in   = READ_COUNT;
         end
      end
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Configuration port: one register, the PHY address, at byte address 0.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      phy_address_in = phy_address_ff;
      if (csr_write && (csr_paddr[2] == CSR_IDX_PHY_ADDRESS)) begin
         phy_address_in = csr_pwdata[PHY_WIDTH-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_IDX_PHY_ADDRESS) begin
         csr_prdata = {{(CSR_DATA_WIDTH-PHY_WIDTH){1'b0}}, phy_address_ff};
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PHASE_IDLE;
         cached_page_ff <= '0;
         frame_shift_ff <= '0;
         bit_count_ff   <= '0;
         pend_write_ff  <= 1'b0;
         pend_reg_ff    <= '0;
         pend_data_ff   <= '0;
         read_shift_ff  <= '0;
         phy_address_ff <= PHY_ADDRESS_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         cached_page_ff <= cached_page_in;
         frame_shift_ff <= frame_shift_in;
         bit_count_ff   <= bit_count_in;
         pend_write_ff  <= pend_write_in;
         pend_reg_ff    <= pend_reg_in;
         pend_data_ff   <= pend_data_in;
         read_shift_ff  <= read_shift_in;
         phy_address_ff <= phy_address_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Result payload, loaded only with a new result.
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_mdio_out_ff    <= rsp_mdio_out_in;
         rsp_mdio_drive_ff  <= rsp_mdio_drive_in;
         rsp_clock_pulse_ff <= rsp_clock_pulse_in;
         rsp_read_valid_ff  <= rsp_read_valid_in;
         rsp_read_data_ff   <= rsp_read_data_in;
         rsp_access_done_ff <= rsp_access_done_in;
         rsp_rejected_ff    <= rsp_rejected_in;
         rsp_busy_res_ff    <= rsp_busy_res_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.mdio_out    = rsp_mdio_out_ff;
   assign rsp_chan.mdio_drive  = rsp_mdio_drive_ff;
   assign rsp_chan.clock_pulse = rsp_clock_pulse_ff;
   assign rsp_chan.read_valid  = rsp_read_valid_ff;
   assign rsp_chan.read_data   = rsp_read_data_ff;
   assign rsp_chan.access_done = rsp_access_done_ff;
   assign rsp_chan.rejected    = rsp_rejected_ff;
   assign rsp_chan.busy_res    = rsp_busy_res_ff;

`ifndef ASSERT_OFF
   // A running frame always has bits left to send.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PHASE_IDLE) |-> (bit_count_ff != '0))
      else $error("frame in progress with an empty bit count");

   // A request during a frame must come back as a rejection.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.func && busy) |=> (rsp_valid_ff && rsp_rejected_ff))
      else $error("request during a frame was not rejected");

   // The last tick of an access frame ends the frame and flags completion.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_chan.func && (phase_ff == PHASE_ACCESS) && (pos == COUNT_ONE))
      |=> ((phase_ff == PHASE_IDLE) && rsp_valid_ff && rsp_access_done_ff))
      else $error("access frame did not complete on its last tick");

   // Read data is only reported together with access completion.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_read_valid_ff) |-> rsp_access_done_ff)
      else $error("read data reported without access completion");
`endif

endmodule

`default_nettype wire

@@ verif/paged_mdio_master_top_tb.sv @@
// ----------------------------------------------------------------------------
// Paged MDIO master testbench
// Sends request and tick items to the paged MDIO master and keeps a model of
// its frame sequencer: page cache, frame shift pattern, bit counter and read
// collection. Every result item is checked against the bit, drive enable,
// clock pulse, read value and status flags that the model predicts, across
// page changes, rejected requests, idle ticks and several PHY addresses.
// ----------------------------------------------------------------------------

package pmdio_tb_pkg;
   import pmdio_pkg::*;

   typedef struct packed {
      logic                  func;
      logic                  is_write;
      logic [ADDR_WIDTH-1:0] reg_addr;
      logic [DATA_WIDTH-1:0] write_data;
      logic                  mdio_in;
   } mdio_item_type;

   typedef struct packed {
      logic                  mdio_out;
      logic                  mdio_drive;
      logic                  clock_pulse;
      logic                  read_valid;
      logic [DATA_WIDTH-1:0] read_data;
      logic                  access_done;
      logic                  rejected;
      logic                  busy_res;
   } mdio_result_type;

   // Released bit periods of a read frame, counted down from the frame end.
   localparam int FIRST_SAMPLE_BIT = 2;
   localparam int LAST_SAMPLE_BIT  = DATA_WIDTH + 1;
   localparam int REPORT_LIMIT     = 10;

   class mdio_line_tracker;
      int unsigned            preamble;
      logic [PHY_WIDTH-1:0]   dev_addr;
      logic [PAGE_WIDTH-1:0]  cached_page;
      logic [FRAME_WIDTH-1:0] frame_bits;
      logic [COUNT_WIDTH-1:0] bits_left;
      phase_type              phase;
      logic                   pend_write;
      logic [REG_WIDTH-1:0]   pend_reg;
      logic [DATA_WIDTH-1:0]  pend_data;
      logic [DATA_WIDTH-1:0]  read_bits;
      mdio_result_type        bus_results_due[$];
      int                     errors;

      function new(int unsigned preamble_len);
         preamble    = preamble_len;
         dev_addr    = PHY_ADDRESS_RESET;
         cached_page = '0;
         frame_bits  = '0;
         bits_left   = '0;
         phase       = PHASE_IDLE;
         pend_write  = 1'b0;
         pend_reg    = '0;
         pend_data   = '0;
         read_bits   = '0;
         errors      = 0;
      endfunction

      function void set_phy(logic [PHY_WIDTH-1:0] value);
         dev_addr = value;
      endfunction

      function bit idle();
         return phase == PHASE_IDLE;
      endfunction

      function int owed();
         return bus_results_due.size();
      endfunction

      function void load_write_frame(logic [REG_WIDTH-1:0] regnum,
                                     logic [DATA_WIDTH-1:0] data);
         frame_bits = {WRITE_START_OP, dev_addr, regnum, WRITE_TURNAROUND, data, 1'b1};
         bits_left  = COUNT_WIDTH'(preamble + WRITE_FRAME_BITS);
      endfunction

      function void start_access();
         read_bits = '0;
         if (pend_write) begin
            load_write_frame(pend_reg, pend_data);
         end else begin
            // Read frame: the bit after the register field is a driven one,
            // the data field is released, and the frame ends on a driven one.
            frame_bits = {1'b0, READ_START_OP, dev_addr, pend_reg, 1'b1,
                          {DATA_WIDTH{1'b0}}, 1'b1};
            bits_left  = COUNT_WIDTH'(preamble + READ_FRAME_BITS);
         end
         phase = PHASE_ACCESS;
      endfunction

      // Works out the result of one accepted item and updates the frame state.
      function void predict_bus(mdio_item_type it);
         mdio_result_type       res;
         bit                    rd;
         int unsigned           r;
         int unsigned           len;
         logic [PAGE_WIDTH-1:0] page;
         res  = '0;
         page = it.reg_addr[ADDR_WIDTH-1:REG_WIDTH];
         if (it.func) begin
            if (phase != PHASE_IDLE) begin
               res.rejected = 1'b1;
               res.busy_res = 1'b1;
               bus_results_due.push_back(res);
               return;
            end
            pend_write = it.is_write;
            pend_reg   = it.reg_addr[REG_WIDTH-1:0];
            pend_data  = it.write_data;
            if (page != cached_page) begin
               load_write_frame(PAGE_SEL_REG, PAGE_SEL_FLAG | DATA_WIDTH'(page));
               cached_page = page;
               read_bits   = '0;
               phase       = PHASE_PAGE;
            end else begin
               start_access();
            end
            return;
         end
         if (phase == PHASE_IDLE) begin
            bus_results_due.push_back(res);
            return;
         end
         rd  = (phase == PHASE_ACCESS) && !pend_write;
         len = rd ? READ_FRAME_BITS : WRITE_FRAME_BITS;
         r   = bits_left;
         if (r == 0) r = 1;
         if (r > len) begin
            res.mdio_out   = 1'b1;
            res.mdio_drive = 1'b1;
         end else if (rd && r >= FIRST_SAMPLE_BIT && r <= LAST_SAMPLE_BIT) begin
            read_bits = {read_bits[DATA_WIDTH-2:0], it.mdio_in};
         end else begin
            res.mdio_out   = frame_bits[r-1];
            res.mdio_drive = 1'b1;
         end
         res.clock_pulse = 1'b1;
         res.busy_res    = 1'b1;
         bits_left       = COUNT_WIDTH'(r - 1);
         if (bits_left == 0) begin
            if (phase == PHASE_PAGE) begin
               start_access();
            end else begin
               phase           = PHASE_IDLE;
               res.access_done = 1'b1;
               if (rd) begin
                  res.read_valid = 1'b1;
                  res.read_data  = read_bits;
               end
            end
         end
         bus_results_due.push_back(res);
      endfunction

      function void check_bus(mdio_result_type got);
         mdio_result_type want;
         if (bus_results_due.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("ERROR %0t: result with none expected: %p", $time, got);
            return;
         end
         want = bus_results_due.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("ERROR %0t: expected %p, got %p", $time, want, got);
         end
      endfunction
   endclass
endpackage

module paged_mdio_master_top_tb;
   import pmdio_pkg::*;
   import pmdio_tb_pkg::*;

   localparam int PREAMBLE_LEN    = PREAMBLE_BITS_DEFAULT;
   // Quiet cycles allowed before a register write and at the end of the run.
   localparam int SETTLE_CYCLES   = 16;
   // Once this many items have gone in, the receiver stops taking results for
   // a long stretch so that the result path fills up and the request channel
   // stalls while items are still being offered.
   localparam int HOLD_OFF_ITEMS  = 400;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int ITEMS_PER_PHASE = 60;
   localparam int RANDOM_PHASES   = 3;
   localparam int RUN_LIMIT       = 3_200_000;
   localparam logic [CSR_ADDR_WIDTH-1:0] PHY_ADDRESS_OFFSET =
      CSR_ADDR_WIDTH'(4 * CSR_IDX_PHY_ADDRESS);

   // Level that the PHY puts on the line during ticks.
   typedef enum {LINE_LOW, LINE_HIGH, LINE_RANDOM} line_mode_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   pmdio_req_if req_bus();
   pmdio_rsp_if rsp_bus();

   mdio_line_tracker tracker;
   int               items_sent;
   bit               steady_send;

   paged_mdio_master_top #(
      .PREAMBLE_BITS(PREAMBLE_LEN)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_bus),
      .rsp_chan   (rsp_bus),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs or stops returning results.
   initial begin
      #(RUN_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // Every result taken by the receiver is compared with the oldest
   // prediction. Values are read at the clock edge before any update lands.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         tracker.check_bus(mdio_result_type'{
            mdio_out:    rsp_bus.mdio_out,
            mdio_drive:  rsp_bus.mdio_drive,
            clock_pulse: rsp_bus.clock_pulse,
            read_valid:  rsp_bus.read_valid,
            read_data:   rsp_bus.read_data,
            access_done: rsp_bus.access_done,
            rejected:    rsp_bus.rejected,
            busy_res:    rsp_bus.busy_res});
      end
   end

   // Receiver. It takes results most of the time, stalls briefly now and
   // then, sometimes for a while, and goes through stretches with no stalls.
   // Once in the run it holds off for a long stretch while items keep coming.
   initial begin
      int stall;
      int r;
      bit steady_take;
      bit held_off;
      stall       = 0;
      steady_take = 1'b0;
      held_off    = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 149) == 0) steady_take = !steady_take;
         if (!held_off && items_sent >= HOLD_OFF_ITEMS && req_bus.valid) begin
            held_off = 1'b1;
            stall    = HOLD_OFF_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_bus.ready <= 1'b0;
         end else if (steady_take) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_bus.ready <= 1'b1;
            end else if (r < 97) begin
               stall = $urandom_range(0, 2);
               rsp_bus.ready <= 1'b0;
            end else begin
               stall = $urandom_range(10, 40);
               rsp_bus.ready <= 1'b0;
            end
         end
         @(posedge clock);
      end
   end

   // Offers one item, after a random gap, and waits until the block takes
   // it. The model is advanced at the edge where the item is accepted. When
   // there is no gap, valid simply stays high for the next item.
   task automatic offer_item(input mdio_item_type it);
      int gap;
      int r;
      if ($urandom_range(0, 119) == 0) steady_send = !steady_send;
      r = $urandom_range(0, 99);
      if (steady_send || r < 65) gap = 0;
      else if (r < 92) gap = $urandom_range(1, 3);
      else if (r < 98) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 30);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.func       <= it.func;
      req_bus.is_write   <= it.is_write;
      req_bus.reg_addr   <= it.reg_addr;
      req_bus.write_data <= it.write_data;
      req_bus.mdio_in    <= it.mdio_in;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      tracker.predict_bus(it);
      items_sent++;
   endtask

   // One MDC period. The request fields are random since the block must
   // ignore them on a tick.
   task automatic send_tick(input line_mode_type mode);
      mdio_item_type it;
      it.func       = 1'b0;
      it.is_write   = 1'($urandom);
      it.reg_addr   = ADDR_WIDTH'($urandom);
      it.write_data = DATA_WIDTH'($urandom);
      case (mode)
         LINE_LOW:  it.mdio_in = 1'b0;
         LINE_HIGH: it.mdio_in = 1'b1;
         default:   it.mdio_in = 1'($urandom);
      endcase
      offer_item(it);
   endtask

   task automatic send_request(input logic is_write, input logic [ADDR_WIDTH-1:0] addr,
                               input logic [DATA_WIDTH-1:0] data);
      mdio_item_type it;
      it.func       = 1'b1;
      it.is_write   = is_write;
      it.reg_addr   = addr;
      it.write_data = data;
      it.mdio_in    = 1'($urandom);
      offer_item(it);
   endtask

   task automatic send_random_request();
      send_request(1'($urandom), ADDR_WIDTH'($urandom), DATA_WIDTH'($urandom));
   endtask

   // Ticks until the frame in flight, page select included, has ended.
   task automatic finish_frame(input line_mode_type mode);
      while (!tracker.idle()) send_tick(mode);
   endtask

   // Stops offering items and waits until every predicted result has come
   // back, plus a few cycles for anything the block might still emit.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (tracker.owed() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write of the PHY address: setup cycle, then access cycle until
   // pready. Only done with the block idle and nothing outstanding.
   task automatic write_phy(input logic [PHY_WIDTH-1:0] value);
      settle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= PHY_ADDRESS_OFFSET;
      csr_pwdata  <= CSR_DATA_WIDTH'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tracker.set_phy(value);
   endtask

   initial begin
      int pick;
      int phase_end;
      tracker     = new(PREAMBLE_LEN);
      items_sent  = 0;
      steady_send = 1'b0;

      reset              <= 1'b1;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.func       <= 1'b0;
      req_bus.is_write   <= 1'b0;
      req_bus.reg_addr   <= '0;
      req_bus.write_data <= '0;
      req_bus.mdio_in    <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, with the PHY address still at its reset value.
      // Idle ticks, one with every unused field at zero and one with all
      // unused fields at one: both must leave the line released.
      offer_item('0);
      offer_item(mdio_item_type'{func: 1'b0, is_write: 1'b1, reg_addr: '1,
                                 write_data: '1, mdio_in: 1'b1});
      // Read on the cached page: no page select, line held high so the
      // collected value is all ones.
      send_request(1'b0, 7'h00, 16'h0000);
      finish_frame(LINE_HIGH);
      // Highest address and data: page select to page 3, then the write.
      send_request(1'b1, 7'h7F, 16'hFFFF);
      finish_frame(LINE_RANDOM);
      // A request right behind an accepted one is rejected, and so is one
      // that arrives while the page select frame is running.
      send_request(1'b1, 7'h20, 16'h1234);
      send_request(1'b0, 7'h41, 16'h0000);
      repeat (5) send_tick(LINE_RANDOM);
      send_request(1'b1, 7'h62, 16'h5555);
      finish_frame(LINE_RANDOM);

      write_phy(5'd31);
      // Read with the line low reads back zero.
      send_request(1'b0, 7'h60, 16'h0000);
      finish_frame(LINE_LOW);
      send_request(1'b1, 7'h00, 16'h0000);
      finish_frame(LINE_RANDOM);
      // Write data is ignored on a read.
      send_request(1'b0, 7'h5F, 16'hFFFF);
      finish_frame(LINE_RANDOM);

      write_phy(5'd0);
      send_request(1'b1, 7'h3F, 16'hA5A5);
      finish_frame(LINE_RANDOM);
      send_request(1'b0, 7'h1F, 16'h0000);
      finish_frame(LINE_RANDOM);
      // Same page, so the access frame starts at once; a request in the
      // middle of it is rejected.
      send_request(1'b1, 7'h05, 16'h8001);
      repeat (40) send_tick(LINE_RANDOM);
      send_request(1'b0, 7'h05, 16'h0000);
      finish_frame(LINE_RANDOM);

      // Random part: each phase runs at a new PHY address. Most of it is
      // complete accesses with random content and the odd rejected request
      // thrown into the frame, the rest idle ticks and request pairs.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_phy(PHY_WIDTH'($urandom));
         phase_end = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               send_random_request();
               while (!tracker.idle()) begin
                  if ($urandom_range(0, 39) == 0) send_random_request();
                  else send_tick(LINE_RANDOM);
               end
            end else if (pick < 90) begin
               repeat ($urandom_range(1, 4)) send_tick(LINE_RANDOM);
            end else begin
               send_random_request();
               send_random_request();
            end
         end
         finish_frame(LINE_RANDOM);
      end

      settle();
      if (tracker.errors == 0 && tracker.owed() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
